>>> rtl/core/salc_pkg.sv
package salc_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned TAG_W  = 64;
  localparam int unsigned CNT_W  = 32;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  // Classified access handed from the front part to the back part.
  typedef struct packed {
    logic [15:0]      set_idx;
    logic [TAG_W-1:0] tag;
  } salc_req_t;

endpackage

>>> rtl/core/salc_front.sv
module salc_front import salc_pkg::*; #(
  parameter int unsigned MaxSetBits = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [3:0]        set_bits_i,
  input  logic [5:0]        block_bits_i,
  output logic              req_valid_o,
  input  logic              req_stall_i,
  output salc_req_t         req_o
);

  logic        full_q;
  salc_req_t   req_q;
  salc_req_t   req_d;
  logic [4:0]  sb;
  logic [6:0]  shift;
  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] set_mask;

  always_comb begin
    sb = (32'(set_bits_i) > MaxSetBits) ? 5'(MaxSetBits) : 5'(set_bits_i);
    shift = 7'(sb) + 7'(block_bits_i);
    shifted = address_i >> block_bits_i;
    set_mask = ~({ADDR_W{1'b1}} << sb);
    req_d.set_idx = 16'(shifted & set_mask);
    req_d.tag = (shift >= 7'd64) ? '0 : (address_i >> shift);
  end

  // One-entry queue slot: take a word when empty or when draining.
  assign stall_o = full_q && req_stall_i;
  assign req_valid_o = full_q;
  assign req_o = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (valid_i && !stall_o) begin
      full_q <= 1'b1;
    end else if (!req_stall_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      req_q <= req_d;
    end
  end

endmodule

>>> rtl/core/salc_back.sv
module salc_back import salc_pkg::*; #(
  parameter int unsigned MaxSetBits = 10,
  parameter int unsigned MaxWays    = 8,
  parameter int unsigned WayW       = 3,
  parameter int unsigned RankW      = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  salc_req_t        req_i,
  input  logic [3:0]       ways_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [1:0]       outcome_o,
  output logic [2:0]       way_used_o,
  output logic [CNT_W-1:0] hits_total_o,
  output logic [CNT_W-1:0] misses_total_o,
  output logic [CNT_W-1:0] evictions_total_o
);

  localparam int unsigned Sets   = 1 << MaxSetBits;
  localparam int unsigned SetW   = MaxSetBits;
  localparam int unsigned LineW  = 1 + TAG_W + RankW;
  localparam int unsigned RowW   = MaxWays * LineW;
  localparam logic [RankW-1:0] RankMax = RankW'(MaxWays - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [RowW-1:0] mem [Sets];
  logic [RowW-1:0] rd_q;
  logic [1:0]      state_q;
  logic [SetW:0]   clr_q;
  logic [SetW-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [CNT_W-1:0] hits_q, misses_q, evicts_q;
  logic [1:0]      outc_q;
  logic [2:0]      way_q;

  logic [MaxWays-1:0]   v;
  logic [TAG_W-1:0]     t [MaxWays];
  logic [RankW-1:0]     r [MaxWays];
  logic [MaxWays-1:0]   inuse;
  logic                 found, free;
  logic [WayW-1:0]      hw, fw, ew, way;
  logic [RankW-1:0]     best, lim;
  logic [RowW-1:0]      row_d;
  logic [1:0]           outc_d;
  logic [4:0]           nw;

  always_comb begin
    nw = (ways_i == 4'd0) ? 5'd1 :
         ((32'(ways_i) > MaxWays) ? 5'(MaxWays) : 5'(ways_i));
    for (int j = 0; j < MaxWays; j++) begin
      v[j] = rd_q[j*LineW + TAG_W + RankW];
      t[j] = rd_q[j*LineW + RankW +: TAG_W];
      r[j] = rd_q[j*LineW +: RankW];
      inuse[j] = (5'(j) < nw);
    end
    found = 1'b0; free = 1'b0; hw = '0; fw = '0; ew = '0; best = '0;
    for (int j = MaxWays - 1; j >= 0; j--) begin
      if (inuse[j] && v[j] && t[j] == tag_q) begin
        found = 1'b1; hw = WayW'(j);
      end
      if (inuse[j] && !v[j]) begin
        free = 1'b1; fw = WayW'(j);
      end
    end
    for (int j = 0; j < MaxWays; j++) begin
      if (inuse[j] && r[j] > best) begin
        best = r[j]; ew = WayW'(j);
      end
    end
    if (found) begin
      way = hw; lim = r[hw]; outc_d = OUT_HIT;
    end else if (free) begin
      way = fw; lim = RankMax; outc_d = OUT_FILL;
    end else begin
      way = ew; lim = r[ew]; outc_d = OUT_EVICT;
    end
    row_d = rd_q;
    for (int j = 0; j < MaxWays; j++) begin
      if (WayW'(j) == way) begin
        row_d[j*LineW +: RankW] = '0;
        if (!found) begin
          row_d[j*LineW + TAG_W + RankW] = 1'b1;
          row_d[j*LineW + RankW +: TAG_W] = tag_q;
        end
      end else if (inuse[j] && v[j] && (r[j] < lim || (free && !found))
                   && r[j] < RankMax) begin
        row_d[j*LineW +: RankW] = r[j] + 1'b1;
      end
    end
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_OUT);
  assign outcome_o = outc_q;
  assign way_used_o = way_q;
  assign hits_total_o = hits_q;
  assign misses_total_o = misses_q;
  assign evictions_total_o = evicts_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mem[clr_q[SetW-1:0]] <= '0;
    end else if (state_q == ST_READ) begin
      mem[set_q] <= row_d;
    end
    rd_q <= mem[req_i.set_idx[SetW-1:0]];
    if (state_q == ST_IDLE) begin
      set_q <= req_i.set_idx[SetW-1:0];
      tag_q <= req_i.tag;
    end
    if (state_q == ST_READ) begin
      outc_q <= outc_d;
      way_q <= 3'(way);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      hits_q <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (SetW+1)'(Sets - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid_i) state_q <= ST_READ;
        end
        ST_READ: begin
          if (found) hits_q <= hits_q + 1'b1;
          else misses_q <= misses_q + 1'b1;
          if (!found && !free) evicts_q <= evicts_q + 1'b1;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/set_assoc_lru_cache_lookup.sv
// Channel | Direction | Handshake         | Payload
// address | in        | valid_i / stall_o | address_i
// result  | out       | valid_o / stall_i | outcome_o, way_used_o, *_total_o
// cfg     | in        | cfg_we_i          | cfg_idx_i, cfg_data_i
// An access goes through the set row read, compare and write back, then the
// result register, where it waits until the output side takes it.
// A one-word queue in the front lets a new address enter while the back works.
// After reset a clearing pass over all 2**MaxSetBits rows (1024) zeroes the store;
// meanwhile only the front queue takes one address. Configuration writes are
// always taken.
module set_assoc_lru_cache_lookup import salc_pkg::*; #(
  parameter int unsigned MaxSetBits = 10,
  parameter int unsigned MaxWays    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [ADDR_W-1:0] address_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [1:0]        outcome_o,
  output logic [2:0]        way_used_o,
  output logic [CNT_W-1:0]  hits_total_o,
  output logic [CNT_W-1:0]  misses_total_o,
  output logic [CNT_W-1:0]  evictions_total_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [5:0]        cfg_data_i
);

  localparam int unsigned WayW  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned RankW = WayW;

  logic [3:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [3:0] ways_q;
  logic       req_valid, req_stall;
  salc_req_t  req;

  // Hold configuration; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 4'd4;
      block_bits_q <= 6'd4;
      ways_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q <= cfg_data_i[3:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        CFG_WAYS:       ways_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  salc_front #(.MaxSetBits(MaxSetBits)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .address_i,
    .set_bits_i(set_bits_q), .block_bits_i(block_bits_q),
    .req_valid_o(req_valid), .req_stall_i(req_stall), .req_o(req)
  );

  salc_back #(.MaxSetBits(MaxSetBits), .MaxWays(MaxWays), .WayW(WayW),
              .RankW(RankW)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_stall_o(req_stall),
    .req_i(req), .ways_i(ways_q), .valid_o, .stall_i, .outcome_o,
    .way_used_o, .hits_total_o, .misses_total_o, .evictions_total_o
  );

endmodule

>>> rtl/core/salc_checker.sv
module salc_checker import salc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_o,
  input logic             stall_i,
  input logic [1:0]       outcome_o,
  input logic [CNT_W-1:0] hits_total_o
);

  a_outcome_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (outcome_o == OUT_HIT || outcome_o == OUT_FILL ||
                 outcome_o == OUT_EVICT)) else $error("bad outcome");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(outcome_o)) else $error("stall drop");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && outcome_o != OUT_HIT |=> $stable(hits_total_o))
    else $error("hit count moved");

endmodule

bind set_assoc_lru_cache_lookup salc_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .stall_i, .outcome_o, .hits_total_o
);

>>> bench/tb.sv
module tb;
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETS_MAX  = 1024;
  localparam int unsigned WAYS_MAX  = 8;
  localparam int unsigned CYCLE_CAP = 2000000;

  // Expected result word for one access.
  typedef struct packed {
    logic [1:0]       outcome;
    logic [2:0]       way;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } lookup_res_t;

  // Tag store shadow plus queue of pending lookup results.
  class lru_scoreboard;
    bit             valid_q [SETS_MAX*WAYS_MAX];
    logic [63:0]    tag_q   [SETS_MAX*WAYS_MAX];
    logic [2:0]     rank_q  [SETS_MAX*WAYS_MAX];
    logic [CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;
    logic [3:0]     set_bits;
    logic [5:0]     block_bits;
    logic [3:0]     ways;
    lookup_res_t    pending_q [$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    n_hit, n_fill, n_evict;

    function new();
      foreach (valid_q[i]) begin
        valid_q[i] = 0;
        tag_q[i]   = '0;
        rank_q[i]  = '0;
      end
      hit_cnt = '0; miss_cnt = '0; evict_cnt = '0;
      set_bits = 4'd4; block_bits = 6'd4; ways = 4'd1;
      errors = 0; checked = 0; n_hit = 0; n_fill = 0; n_evict = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] val);
      case (idx)
        CFG_SET_BITS:   set_bits   = val[3:0];
        CFG_BLOCK_BITS: block_bits = val;
        CFG_WAYS:       ways       = val[3:0];
        default: ;
      endcase
    endfunction

    // Age the other valid ways of a set whose rank is below lim.
    function void age_set(int unsigned base, int unsigned nw, int unsigned self,
                          int unsigned lim);
      for (int unsigned j = 0; j < nw; j++) begin
        if (j != self && valid_q[base+j] && rank_q[base+j] < lim &&
            rank_q[base+j] < WAYS_MAX-1)
          rank_q[base+j] = rank_q[base+j] + 1;
      end
    endfunction

    // Note an accepted address: look it up and queue the expected word.
    function void note_access(logic [63:0] addr);
      int unsigned sb, bb, nw, shift, set_idx, base, way;
      logic [63:0] tag;
      bit found, free;
      lookup_res_t r;
      logic [2:0] best;
      sb = (set_bits > 10) ? 10 : 32'(set_bits);
      bb = 32'(block_bits);
      nw = (ways == 0) ? 1 : ((ways > WAYS_MAX) ? WAYS_MAX : 32'(ways));
      shift = sb + bb;
      tag = (shift >= 64) ? 64'd0 : (addr >> shift);
      set_idx = 32'((addr >> bb) & ((64'd1 << sb) - 1));
      base = set_idx * WAYS_MAX;
      found = 0; free = 0; way = 0;
      for (int unsigned j = 0; j < nw; j++)
        if (!found && valid_q[base+j] && tag_q[base+j] == tag) begin
          found = 1; way = j;
        end
      if (found) begin
        hit_cnt++; n_hit++;
        age_set(base, nw, way, rank_q[base+way]);
        r.outcome = OUT_HIT;
      end else begin
        miss_cnt++;
        for (int unsigned j = 0; j < nw; j++)
          if (!free && !valid_q[base+j]) begin
            free = 1; way = j;
          end
        if (free) begin
          n_fill++;
          age_set(base, nw, way, WAYS_MAX);
          r.outcome = OUT_FILL;
        end else begin
          best = 0; way = 0;
          for (int unsigned j = 0; j < nw; j++)
            if (rank_q[base+j] > best) begin
              best = rank_q[base+j]; way = j;
            end
          evict_cnt++; n_evict++;
          age_set(base, nw, way, rank_q[base+way]);
          r.outcome = OUT_EVICT;
        end
        valid_q[base+way] = 1;
        tag_q[base+way]   = tag;
      end
      rank_q[base+way] = '0;
      r.way = way[2:0];
      r.hits = hit_cnt; r.misses = miss_cnt; r.evictions = evict_cnt;
      pending_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               checked, what, got, want);
      errors++;
    endtask

    // Check one accepted result word against the oldest expectation.
    task check_result(lookup_res_t got);
      lookup_res_t want;
      if (pending_q.size() == 0) begin
        $display("unexpected result word %0d", checked);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.outcome !== want.outcome) report("outcome", got.outcome, want.outcome);
        if (got.way !== want.way) report("way_used", got.way, want.way);
        if (got.hits !== want.hits) report("hits_total", got.hits, want.hits);
        if (got.misses !== want.misses) report("misses_total", got.misses, want.misses);
        if (got.evictions !== want.evictions)
          report("evictions_total", got.evictions, want.evictions);
      end
      checked++;
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              valid_i = 1'b0;
  logic              stall_o;
  logic [ADDR_W-1:0] address_i = '0;
  logic              valid_o;
  logic              stall_i = 1'b0;
  logic [1:0]        outcome_o;
  logic [2:0]        way_used_o;
  logic [CNT_W-1:0]  hits_total_o, misses_total_o, evictions_total_o;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [5:0]        cfg_data_i = '0;

  set_assoc_lru_cache_lookup dut (.*);

  always #5 clk_i = ~clk_i;

  lru_scoreboard sb = new();
  int unsigned cycles = 0;
  bit          hold_long = 0;   // sender asks the receiver for one long hold-off
  bit          stim_done = 0;

  // Cycle limit: covers the clearing pass, every stall and every gap many times.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL set_assoc_lru_cache_lookup");
      $finish;
    end
  end

  // Monitor: sample accepted result words at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      sb.check_result({outcome_o, way_used_o, hits_total_o, misses_total_o,
                       evictions_total_o});
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_long = 0;
      end else if ($urandom_range(0, 3) == 0 && !stim_done) begin
        stall_i <= 1'b1;
        n = gap_len() + 1;
        repeat (n) @(posedge clk_i);
      end else begin
        stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Offer one address word and hold it until taken; optional gap afterwards.
  task automatic send_address(logic [63:0] addr, bit no_gap);
    int unsigned g;
    valid_i   <= 1'b1;
    address_i <= addr;
    do @(posedge clk_i); while (stall_o);
    sb.note_access(addr);
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Let every expected word arrive, then allow the pipeline to settle.
  task automatic drain();
    valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register, then drop the enable.
  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Build an address from set, tag and offset under the current settings.
  function automatic logic [63:0] make_addr(logic [63:0] tag, int unsigned set_idx);
    int unsigned sbits, bbits;
    logic [63:0] a;
    sbits = (sb.set_bits > 10) ? 10 : 32'(sb.set_bits);
    bbits = 32'(sb.block_bits);
    a = {$urandom, $urandom} & ((64'd1 << bbits) - 1);
    a |= (64'(set_idx) & ((64'd1 << sbits) - 1)) << bbits;
    if (sbits + bbits < 64) a |= tag << (sbits + bbits);
    return a;
  endfunction

  // Working set per phase: a few tags on a few sets so hits and evictions mix.
  task automatic random_phase(int unsigned count);
    int unsigned nsets, ntags;
    logic [63:0] a;
    nsets = $urandom_range(1, 4);
    ntags = $urandom_range(1, 12);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        a = {$urandom, $urandom};
      else
        a = make_addr($urandom_range(0, ntags - 1) ^ (i[0] ? 64'hFFFF_0000_0000_0000 : 0),
                      $urandom_range(0, nsets - 1));
      send_address(a, 1'b0);
    end
  endtask

  initial begin
    logic [5:0] cfgs [8][3];
    cfgs = '{'{6'd1, 6'd1, 6'd1}, '{6'd10, 6'd32, 6'd8}, '{6'd2, 6'd4, 6'd4},
             '{6'd15, 6'd54, 6'd8}, '{6'd0, 6'd0, 6'd0}, '{6'd3, 6'd63, 6'd15},
             '{6'd1, 6'd6, 6'd2}, '{6'd4, 6'd5, 6'd8}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, address extremes, repeat hits, eviction in one way.
    send_address(64'd0, 1'b1);
    send_address(64'd0, 1'b1);
    send_address(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_address(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_address(64'h0000_0000_0000_0100, 1'b0);
    send_address(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_address(64'h5555_5555_5555_5555, 1'b0);
    drain();
    // Eight ways: fill all, evict the oldest, hit, then evict again.
    write_reg(CFG_WAYS, 6'd8);
    for (int unsigned t = 0; t < 9; t++) send_address(make_addr(t, 0), 1'b1);
    send_address(make_addr(3, 0), 1'b0);
    send_address(make_addr(20, 0), 1'b0);
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    hold_long = 1;
    for (int unsigned i = 0; i < 20; i++) send_address(make_addr(i % 5, 1), 1'b1);
    drain();

    // Phases under several settings; ranks carry across changes on purpose.
    for (int unsigned p = 0; p < 16; p++) begin
      for (int unsigned r = 0; r < 3; r++)
        write_reg(r[1:0], (p < 8) ? cfgs[p][r] : 6'($urandom_range(0, 63)));
      random_phase(95);
      drain();
    end
    stim_done = 1;
    drain();
    repeat (50) @(posedge clk_i);

    $display("checked %0d result words: %0d hits, %0d fills, %0d evictions",
             sb.checked, sb.n_hit, sb.n_fill, sb.n_evict);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS set_assoc_lru_cache_lookup");
    end else begin
      $display("FAIL set_assoc_lru_cache_lookup");
    end
    $finish;
  end

endmodule

>>> set_assoc_lru_cache_lookup.f
rtl/core/salc_pkg.sv
rtl/core/salc_front.sv
rtl/core/salc_back.sv
rtl/core/set_assoc_lru_cache_lookup.sv
rtl/core/salc_checker.sv
bench/tb.sv
